>>> src/ryuv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ryuv_pkg
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package ryuv_pkg;

    // Longest line that the line store holds, and the tallest frame.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Configuration register layout.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Column and row counters, and the widths used to compare them with a dimension.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WDIM_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int HDIM_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    localparam int PIX_W  = 24;
    localparam int COMP_W = 8;

    // Depth of the queue between the front and the back; a power of two.
    localparam int FIFO_DEPTH = 2;

    // How the chroma of a pixel is formed.
    typedef enum logic [2:0] {
        CLS_NONE,     // no block completes here
        CLS_QUAD,     // full 2x2 block
        CLS_VPAIR,    // odd right edge: pixel above and current pixel
        CLS_HPAIR,    // odd bottom edge: left pixel and current pixel
        CLS_SINGLE    // odd corner: current pixel alone
    } ryuv_class_t;

    // One classified and averaged pixel, handed from the front to the back.
    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] avg_red;
        logic [COMP_W-1:0] avg_green;
        logic [COMP_W-1:0] avg_blue;
        logic              chroma_valid;
        logic              frame_end;
    } ryuv_item_t;

endpackage
`default_nettype wire

>>> src/ryuv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ryuv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ryuv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/ryuv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ryuv_front
// Accepts pixels, tracks the position in the frame, keeps the line store and
// forms the averaged chroma components of each completed block.
// ----------------------------------------------------------------------------
module ryuv_front import ryuv_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [PIX_W-1:0]     in_pixel,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output ryuv_item_t                push_item
);

    logic [CFG_W-1:0]  frame_width_reg, frame_height_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [WDIM_W-1:0] w_eff, col_plus;
    logic [HDIM_W-1:0] h_eff, row_plus;
    logic              last_col, last_row, accept;
    ryuv_class_t       cls;

    logic              st_valid_reg;
    logic [PIX_W-1:0]  st_px_reg;
    logic              st_col_odd_reg;
    ryuv_class_t       st_class_reg;
    logic              st_frame_end_reg;
    logic [PIX_W-1:0]  left_reg, prev_up_reg, up_px;
    logic              advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective dimensions: zero acts as one, oversize is clipped.
    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WDIM_W'(1);
        end else if (WDIM_W'(frame_width_reg) > WDIM_W'(MAX_WIDTH)) begin
            w_eff = WDIM_W'(MAX_WIDTH);
        end else begin
            w_eff = WDIM_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = HDIM_W'(1);
        end else if (HDIM_W'(frame_height_reg) > HDIM_W'(MAX_HEIGHT)) begin
            h_eff = HDIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = HDIM_W'(frame_height_reg);
        end
    end

    assign col_plus = WDIM_W'(col_reg) + WDIM_W'(1);
    assign row_plus = HDIM_W'(row_reg) + HDIM_W'(1);
    assign last_col = col_plus >= w_eff;
    assign last_row = row_plus >= h_eff;

    always_comb begin
        if (row_reg[0] && col_reg[0]) begin
            cls = CLS_QUAD;
        end else if (row_reg[0] && last_col) begin
            cls = CLS_VPAIR;
        end else if (!row_reg[0] && last_row && col_reg[0]) begin
            cls = CLS_HPAIR;
        end else if (!row_reg[0] && last_row && last_col) begin
            cls = CLS_SINGLE;
        end else begin
            cls = CLS_NONE;
        end
    end

    always_comb begin
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : ROW_W'(row_plus);
        end else begin
            col_next = COL_W'(col_plus);
            row_next = row_reg;
        end
    end

    assign advance  = st_valid_reg && push_ready;
    assign in_ready = !st_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Even lines are written; odd lines read the pixel above at the same column.
    ryuv_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .aclk (aclk),
        .we   (accept && !row_reg[0]),
        .waddr(col_reg),
        .wdata(in_pixel),
        .re   (accept),
        .raddr(col_reg),
        .rdata(up_px)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (advance) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_px_reg        <= in_pixel;
            st_col_odd_reg   <= col_reg[0];
            st_class_reg     <= cls;
            st_frame_end_reg <= last_col && last_row;
        end
    end

    // The pixel above-left is the one read for the previous pixel of the same line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (advance && !st_col_odd_reg) begin
            left_reg <= st_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prev_up_reg <= up_px;
        end
    end

    always_comb begin
        logic [COMP_W-1:0] cur, up, upl, lft;
        logic [COMP_W-1:0] avg [3];
        for (int s = 0; s < 3; s++) begin
            cur = st_px_reg[PIX_W-1-COMP_W*s -: COMP_W];
            up  = up_px[PIX_W-1-COMP_W*s -: COMP_W];
            upl = prev_up_reg[PIX_W-1-COMP_W*s -: COMP_W];
            lft = left_reg[PIX_W-1-COMP_W*s -: COMP_W];
            case (st_class_reg)
                CLS_QUAD:   avg[s] = (upl >> 2) + (up >> 2) + (lft >> 2) + (cur >> 2);
                CLS_VPAIR:  avg[s] = (up >> 1) + (cur >> 1);
                CLS_HPAIR:  avg[s] = (lft >> 1) + (cur >> 1);
                CLS_SINGLE: avg[s] = cur;
                default:    avg[s] = '0;
            endcase
        end
        push_item.red          = st_px_reg[23:16];
        push_item.green        = st_px_reg[15:8];
        push_item.blue         = st_px_reg[7:0];
        push_item.avg_red      = avg[0];
        push_item.avg_green    = avg[1];
        push_item.avg_blue     = avg[2];
        push_item.chroma_valid = st_class_reg != CLS_NONE;
        push_item.frame_end    = st_frame_end_reg;
    end

    assign push_valid = st_valid_reg;

endmodule
`default_nettype wire

>>> src/ryuv_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ryuv_fifo
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module ryuv_fifo import ryuv_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire ryuv_item_t push_item,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output ryuv_item_t      pop_item
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    ryuv_item_t         entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

>>> src/ryuv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ryuv_back
// Color matrix: luma of each pixel and chroma of each completed block, into
// the output register.
// ----------------------------------------------------------------------------
module ryuv_back import ryuv_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire ryuv_item_t        pop_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [COMP_W-1:0]      luma,
    output logic                   chroma_valid,
    output logic [COMP_W-1:0]      chroma_blue,
    output logic [COMP_W-1:0]      chroma_red,
    output logic                   frame_end
);

    logic              out_valid_reg;
    logic [COMP_W-1:0] luma_reg, cb_reg, cr_reg;
    logic              cv_reg, fe_reg;
    logic [15:0]       y_sum, cb_sum, cr_sum;
    logic [COMP_W-1:0] luma_next, cb_next, cr_next;

    assign pop_ready = !out_valid_reg || out_ready;

    // All sums stay within 16 bits; the 32768 offset keeps the chroma sums positive.
    always_comb begin
        y_sum  = 16'd66 * 16'(pop_item.red) + 16'd129 * 16'(pop_item.green)
               + 16'd25 * 16'(pop_item.blue);
        cb_sum = 16'd32768 + 16'd112 * 16'(pop_item.avg_blue)
               - 16'd38 * 16'(pop_item.avg_red) - 16'd74 * 16'(pop_item.avg_green);
        cr_sum = 16'd32768 + 16'd112 * 16'(pop_item.avg_red)
               - 16'd94 * 16'(pop_item.avg_green) - 16'd18 * 16'(pop_item.avg_blue);
        luma_next = y_sum[15:8] + 8'd16;
        cb_next   = pop_item.chroma_valid ? cb_sum[15:8] : '0;
        cr_next   = pop_item.chroma_valid ? cr_sum[15:8] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop_ready) begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            luma_reg <= luma_next;
            cb_reg   <= cb_next;
            cr_reg   <= cr_next;
            cv_reg   <= pop_item.chroma_valid;
            fe_reg   <= pop_item.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_valid = cv_reg;
    assign chroma_blue  = cb_reg;
    assign chroma_red   = cr_reg;
    assign frame_end    = fe_reg;

endmodule
`default_nettype wire

>>> src/rgb_to_yuv420_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// RGB to YUV 4:2:0 converter, BT.601 integer coefficients, raster order.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Ports                      Carries
//  --------  ---  -------------------------  ---------------------------------------
//  s_        in   s_tvalid/s_tready/s_tdata  one RGB pixel per request
//  m_        out  m_tvalid/m_tready/m_tdata  Y of the pixel, Cb/Cr of a completed
//                 m_tuser/m_tlast            block, chroma flag and end of frame
//  cfg_      in   cfg_we/cfg_index/cfg_wdata frame width (index 0), height (index 1)
//
// One pixel is accepted per clock when the output side keeps up; each pixel's result
// passes the front stage with the line store read, the queue and the output register
// before it appears on m_. The line store takes one write and one read per pixel on
// separate ports, which sustains that rate.
// Reset clears the counters, the left pixel hold and the handshake state; the line
// store holds no reset value and needs no clearing pass, so the block is ready as soon
// as reset ends. A stall at the output fills the output register, the two-entry queue
// and the front stage register before s_tready drops; there is no combinational path
// from m_tready to s_tready.
//
// Each pixel produces luma. The pixel that completes a 2x2 block (odd column of an
// odd line) also produces chroma from the averages of the block's four pixels, with
// each quarter truncated. At an odd right or bottom edge two pixels are averaged,
// and at the odd corner the last pixel stands alone. Even lines go to the line store
// so the odd line below can find the pixels above it.
//
module rgb_to_yuv420_converter_core import ryuv_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // Pixel input.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // Result output.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // luma [7:0], chroma_blue [15:8],
                                                 // chroma_red [23:16]
    output logic                      m_tuser,   // chroma_valid
    output logic                      m_tlast    // frame_end
);

    logic             push_valid, push_ready, pop_valid, pop_ready;
    ryuv_item_t       push_item, pop_item;
    logic [PIX_W-1:0] in_pixel;
    logic [7:0]       luma, chroma_blue, chroma_red;

    // The line store and datapath keep pixels as {red, green, blue}.
    assign in_pixel = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    ryuv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (in_pixel),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item)
    );

    ryuv_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    ryuv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .luma        (luma),
        .chroma_valid(m_tuser),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .frame_end   (m_tlast)
    );

    assign m_tdata = {chroma_red, chroma_blue, luma};

endmodule
`default_nettype wire
